### hdl/mtvs_pkg.sv
// ----------------------------------------------------------------------------
// mtvs_pkg
// Shared types and constants of the masked trilinear voxel sampler: beat
// layouts of the request and response channels and register indexes.
// ----------------------------------------------------------------------------
package mtvs_pkg;

   // fixed field widths of the channels
   localparam int OPCODE_W = 1;
   localparam int ADDR_FIELD_W = 18;
   localparam int DIST_W = 16;
   localparam int COORD_W = 16;
   localparam int SIZE_W = 7;
   localparam int CSR_IDX_W = 2;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_WRITE = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_QUERY = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 2'd2;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   // request beat
   typedef struct packed {
      logic [OPCODE_W-1:0]     opcode;
      logic [ADDR_FIELD_W-1:0] voxel_address;
      logic signed [DIST_W-1:0] voxel_value;
      logic                    voxel_observed;
      logic signed [COORD_W-1:0] query_x;
      logic signed [COORD_W-1:0] query_y;
      logic signed [COORD_W-1:0] query_z;
   } req_type;

   // response beat
   typedef struct packed {
      logic signed [DIST_W-1:0] sample_value;
      logic                     sample_found;
   } rsp_type;

endpackage

### hdl/mtvs_volume_ram.sv
// ----------------------------------------------------------------------------
// mtvs_volume_ram
// Single-port voxel memory: one write or one read per cycle, read data
// registered.
// ----------------------------------------------------------------------------
module mtvs_volume_ram #(
   parameter int DEPTH = 262144,
   parameter int ADDR_W = 18,
   parameter int WIDTH = 17
) (
   input  logic              clock,
   input  logic              write_en,
   input  logic              read_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[addr] <= wdata;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (read_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### hdl/mtvs_divider.sv
// ----------------------------------------------------------------------------
// mtvs_divider
// Restoring divider, one quotient bit per cycle. Gives floor(num / den) for
// signed num and positive den, where the quotient magnitude fits QB bits.
// ----------------------------------------------------------------------------
module mtvs_divider #(
   parameter int NW = 47,
   parameter int DW = 29,
   parameter int QB = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic signed [NW-1:0] num,
   input  logic [DW-1:0]        den,
   output logic                 done,
   output logic signed [QB:0]   quot
);

   localparam int CNT_W = $clog2(QB + 1);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [QB-1:0]     abits_ff, abits_in;
   logic [QB-1:0]     q_ff, q_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NW-1:0]     mag;
   logic [DW:0]       trial;
   logic [DW:0]       diff;

   // magnitude: for negative num, floor(num/den) = ~floor(~num/den)
   assign mag = num[NW-1] ? ~num : num;
   assign trial = {rem_ff, abits_ff[QB-1]};
   assign diff = trial - {1'b0, den};

   // one bit per step
   always_comb begin
      run_in = run_ff;
      done_in = 1'b0;
      neg_in = neg_ff;
      rem_in = rem_ff;
      abits_in = abits_ff;
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (start) begin
         run_in = 1'b1;
         neg_in = num[NW-1];
         rem_in = mag[QB+DW-1:QB];
         abits_in = mag[QB-1:0];
         q_in = '0;
         cnt_in = CNT_W'(QB);
      end else if (run_ff) begin
         if (trial >= {1'b0, den}) begin
            rem_in = diff[DW-1:0];
            q_in = {q_ff[QB-2:0], 1'b1};
         end else begin
            rem_in = trial[DW-1:0];
            q_in = {q_ff[QB-2:0], 1'b0};
         end
         abits_in = {abits_ff[QB-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      abits_ff <= abits_in;
      q_ff <= q_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? $signed(~{1'b0, q_ff}) : $signed({1'b0, q_ff});

endmodule

### hdl/masked_trilinear_voxel_sampler.sv
// ----------------------------------------------------------------------------
// masked_trilinear_voxel_sampler
// Voxel volume of signed distances with observed flags; queries return the
// trilinear mean of the in-range, observed corners around a point.
//
//   channel  ports                               direction  beat
//   req      start, busy, req_data               in         write or query
//   rsp      rsp_valid, rsp_data                 out        one per query
//   csr      csr_valid, csr_ready, csr_index,    in         size register
//            csr_wdata
//
// A write goes to memory at its accept edge.
// A query keeps busy high from its accept edge through its response: four
// phases per corner on the single memory port (address, read, weight,
// accumulate), then the serial divider and the response; the divider is
// skipped when no corner weight remains.
// Reset clears control and restores the sizes; the voxel memory keeps
// whatever it holds. The response strobe lasts one cycle and is not stalled.
// ----------------------------------------------------------------------------
module masked_trilinear_voxel_sampler #(
   parameter int MAX_DIM = 64,
   parameter int FRAC_BITS = 8,
   parameter int VALUE_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  mtvs_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output mtvs_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mtvs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mtvs_pkg::SIZE_W-1:0]      csr_wdata
);

   import mtvs_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int IDX_W = $clog2(MAX_DIM);
   localparam int LIM_W = $clog2(MAX_DIM + 1);
   localparam int AW = FRAC_BITS + 1;
   localparam int WXY_W = 2 * AW;
   localparam int CW = 3 * AW;
   localparam int P1_W = VALUE_BITS + WXY_W + 1;
   localparam int SW = VALUE_BITS + 3 * FRAC_BITS + 5;
   localparam int TW = 3 * FRAC_BITS + 4;
   localparam int NW = SW + 2;
   localparam int DW = TW + 1;
   localparam int ROW_W = IDX_W + LIM_W + 1;
   localparam int LIN_W = ROW_W + LIM_W + 1;
   localparam int RAM_W = VALUE_BITS + 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CORNER = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_RESULT = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [1:0]        phase_ff, phase_in;
   logic [2:0]        corner_ff, corner_in;
   logic [SIZE_W-1:0] size_ff [3];
   logic [LIM_W-1:0]  lim [3];

   logic [IDX_W-1:0]  idx_ff [3][2];
   logic [AW-1:0]     wgt_ff [3][2];
   logic [IDX_W-1:0]  idx_in [3][2];
   logic [AW-1:0]     wgt_in [3][2];

   logic              live_ff, live_in;
   logic              hit_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [WXY_W-1:0]  wxy_ff;
   logic [AW-1:0]     wz_ff;
   logic signed [P1_W-1:0] prod1_ff;
   logic [CW-1:0]     w_ff;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic [TW-1:0]     total_ff, total_in;

   logic              accept;
   logic              ram_we;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_addr;
   logic [RAM_W-1:0]  ram_wdata;
   logic [RAM_W-1:0]  ram_rdata;
   logic [31:0]       val_ext;
   logic [ADDR_W+ADDR_FIELD_W-1:0] waddr_ext;
   logic              waddr_ok;

   logic              dx, dy, dz;
   logic [LIN_W-1:0]  lin_addr;
   logic [ROW_W+LIM_W-1:0] row_prod;
   logic [IDX_W+LIM_W-1:0] zy_prod;
   logic signed [SW-1:0] prod2;

   logic              div_start;
   logic              div_start_ff;
   logic              div_done;
   logic signed [VALUE_BITS:0] div_quot;
   logic signed [NW-1:0] div_num;
   logic [DW-1:0]     div_den;

   logic signed [VALUE_BITS-1:0] sat_val;
   logic [VALUE_BITS+DIST_W-1:0] sat_ext;
   logic signed [DIST_W-1:0] value_ff, value_in;
   logic              found_ff, found_in;

   assign accept = start && !busy;
   assign busy = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;

   // size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff[0] <= SIZE_RESET;
         size_ff[1] <= SIZE_RESET;
         size_ff[2] <= SIZE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SIZE_X: size_ff[0] <= csr_wdata;
            CSR_SIZE_Y: size_ff[1] <= csr_wdata;
            CSR_SIZE_Z: size_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sizes in use, saturated to the volume edge
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if ({2'b0, size_ff[a]} > 9'(MAX_DIM)) begin
            lim[a] = LIM_W'(MAX_DIM);
         end else begin
            lim[a] = LIM_W'(size_ff[a]);
         end
      end
   end

   // axis split: base index, fraction weights, range masks
   always_comb begin
      logic signed [COORD_W-1:0] c;
      logic signed [COORD_W:0]   b0;
      logic signed [COORD_W:0]   b1;
      logic signed [COORD_W:0]   lm;
      logic [FRAC_BITS-1:0]      frac;
      for (int a = 0; a < 3; a++) begin
         unique case (a)
            0: c = req_data.query_x;
            1: c = req_data.query_y;
            default: c = req_data.query_z;
         endcase
         frac = c[FRAC_BITS-1:0];
         b0 = (COORD_W + 1)'(c >>> FRAC_BITS);
         b1 = b0 + (COORD_W + 1)'(1);
         lm = $signed({{(COORD_W + 1 - LIM_W){1'b0}}, lim[a]});
         idx_in[a][0] = b0[IDX_W-1:0];
         idx_in[a][1] = b1[IDX_W-1:0];
         wgt_in[a][0] = AW'(1 << FRAC_BITS) - {1'b0, frac};
         wgt_in[a][1] = {1'b0, frac};
         if (b0 < 0 || b0 >= lm) begin
            wgt_in[a][0] = '0;
         end
         if (b1 < 0 || b1 >= lm) begin
            wgt_in[a][1] = '0;
         end
      end
   end

   // query registers
   always_ff @(posedge clock) begin
      if (accept && req_data.opcode == OP_QUERY) begin
         idx_ff <= idx_in;
         wgt_ff <= wgt_in;
      end
   end

   // corner select
   assign dx = corner_ff[0];
   assign dy = corner_ff[1];
   assign dz = corner_ff[2];

   // row of the corner, then linear address
   assign zy_prod = idx_ff[2][dz] * lim[1];
   assign row_prod = row_ff * lim[0];
   assign lin_addr = LIN_W'(row_prod) + LIN_W'(idx_ff[0][dx]);
   assign live_in = (wgt_ff[0][dx] != '0) && (wgt_ff[1][dy] != '0) &&
                    (wgt_ff[2][dz] != '0);

   // corner pipeline registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_CORNER) begin
         unique case (phase_ff)
            2'd0: begin
               row_ff <= ROW_W'(zy_prod) + ROW_W'(idx_ff[1][dy]);
               wxy_ff <= wgt_ff[0][dx] * wgt_ff[1][dy];
               wz_ff <= wgt_ff[2][dz];
               live_ff <= live_in;
            end
            2'd2: begin
               hit_ff <= live_ff && ram_rdata[VALUE_BITS];
               prod1_ff <= $signed(ram_rdata[VALUE_BITS-1:0]) *
                           $signed({1'b0, wxy_ff});
               w_ff <= CW'(wxy_ff) * CW'(wz_ff);
            end
            default: ;
         endcase
      end
   end

   assign prod2 = SW'(prod1_ff) * SW'($signed({1'b0, wz_ff}));

   // memory port: writes at accept, corner reads in phase one
   assign val_ext = {16'b0, req_data.voxel_value};
   assign waddr_ext = {{ADDR_W{1'b0}}, req_data.voxel_address};
   assign waddr_ok = waddr_ext < (ADDR_W + ADDR_FIELD_W)'(DEPTH);
   assign ram_we = accept && req_data.opcode == OP_WRITE && waddr_ok;
   assign ram_re = state_ff == ST_CORNER && phase_ff == 2'd1 && live_ff;
   assign ram_addr = ram_we ? waddr_ext[ADDR_W-1:0] : lin_addr[ADDR_W-1:0];
   assign ram_wdata = {req_data.voxel_observed, val_ext[VALUE_BITS-1:0]};

   mtvs_volume_ram #(
      .DEPTH(DEPTH),
      .ADDR_W(ADDR_W),
      .WIDTH(RAM_W)
   ) u_ram (
      .clock(clock),
      .write_en(ram_we),
      .read_en(ram_re),
      .addr(ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   // rounded mean: floor((2S + W) / 2W)
   assign div_num = NW'($signed({sum_ff, 1'b0})) +
                    $signed({{(NW - TW){1'b0}}, total_ff});
   assign div_den = {total_ff, 1'b0};
   assign div_start = state_ff == ST_CORNER && phase_ff == 2'd3 &&
                      corner_in == 3'd0 && total_in != '0;

   mtvs_divider #(
      .NW(NW),
      .DW(DW),
      .QB(VALUE_BITS)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start_ff),
      .num(div_num),
      .den(div_den),
      .done(div_done),
      .quot(div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= div_start;
      end
   end

   // saturate to the value range, then fit the output field
   always_comb begin
      if (div_quot > $signed((VALUE_BITS + 1)'((1 << (VALUE_BITS - 1)) - 1))) begin
         sat_val = {1'b0, {(VALUE_BITS - 1){1'b1}}};
      end else if (div_quot < -$signed((VALUE_BITS + 1)'(1 << (VALUE_BITS - 1)))) begin
         sat_val = {1'b1, {(VALUE_BITS - 1){1'b0}}};
      end else begin
         sat_val = div_quot[VALUE_BITS-1:0];
      end
   end
   assign sat_ext = {{DIST_W{sat_val[VALUE_BITS-1]}}, sat_val};

   // sequencer
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      corner_in = corner_ff;
      sum_in = sum_ff;
      total_in = total_ff;
      value_in = value_ff;
      found_in = found_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.opcode == OP_QUERY) begin
               state_in = ST_CORNER;
               phase_in = 2'd0;
               corner_in = 3'd0;
               sum_in = '0;
               total_in = '0;
            end
         end
         ST_CORNER: begin
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               if (hit_ff) begin
                  sum_in = sum_ff + prod2;
                  total_in = total_ff + TW'(w_ff);
               end
               corner_in = corner_ff + 3'd1;
               if (corner_ff == 3'd7) begin
                  if (total_in == '0) begin
                     state_in = ST_RESULT;
                     value_in = '0;
                     found_in = 1'b0;
                  end else begin
                     state_in = ST_DIVIDE;
                  end
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_RESULT;
               value_in = sat_ext[DIST_W-1:0];
               found_in = 1'b1;
            end
         end
         ST_RESULT: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 2'd0;
         corner_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         corner_ff <= corner_in;
      end
   end

   // accumulators and result
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      total_ff <= total_in;
      value_ff <= value_in;
      found_ff <= found_in;
   end

   assign rsp_valid = (state_ff == ST_RESULT);
   assign rsp_data = {value_ff, found_ff};

   // no memory write while a query owns the port
   assert property (@(posedge clock) disable iff (reset) ram_we |-> !busy)
      else $error("voxel write during a query");

   // a result beat always follows query work
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_CORNER || state_ff == ST_DIVIDE))
      else $error("result beat without a query");

   // empty result carries zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.sample_found) |-> rsp_data.sample_value == '0)
      else $error("not-found result with nonzero value");

   // divider only runs after some weight was accumulated
   assert property (@(posedge clock) disable iff (reset)
      div_start_ff |-> total_ff != '0)
      else $error("divide by zero weight");

   // corner counter rests at zero when idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (corner_ff == 3'd0 && phase_ff == 2'd0))
      else $error("corner sequencer not at rest");

endmodule

### dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the masked trilinear voxel sampler. Voxel writes
// and point queries go in on the command channel. A scoreboard keeps its own
// copy of the volume and the size registers and works out the expected
// weighted mean of every query. Several volume sizes are run, from zero and
// one voxel up to sizes that saturate.
// ----------------------------------------------------------------------------
module testbench;
   import mtvs_pkg::*;

   localparam int STORE_DEPTH = 64 * 64 * 64;
   localparam int DRAIN_CYCLES = 80;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_valid;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [SIZE_W-1:0] csr_wdata = '0;

   // scoreboard state
   req_type pending_cmds[$];
   rsp_type expected_samples[$];
   logic [16:0] volume_copy[int];
   bit planned_voxels[int];
   int size_x = 64, size_y = 64, size_z = 64;
   bit beat_taken = 0;
   int drive_count = 0;
   int fail_count = 0;
   int query_count = 0;
   int found_count = 0;
   int write_count = 0;

   masked_trilinear_voxel_sampler i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   // one axis: base index and the two per-axis weights, masked by size
   function automatic void split_axis(input logic signed [15:0] c, input int size,
                                      output int base, output longint wlo,
                                      output longint whi);
      int lim;
      longint frac;
      lim = (size > 64) ? 64 : size;
      frac = c & 16'h00ff;
      base = c >>> 8;
      whi = frac;
      wlo = 256 - frac;
      if (base < 0 || base >= lim) wlo = 0;
      if (base + 1 < 0 || base + 1 >= lim) whi = 0;
   endfunction

   // weights and linear addresses of the eight corners
   function automatic void corner_weights(input req_type r, output longint w[8],
                                          output int addr[8]);
      int bx, by, bz, sxl, syl, dx, dy, dz;
      longint wx[2], wy[2], wz[2];
      sxl = (size_x > 64) ? 64 : size_x;
      syl = (size_y > 64) ? 64 : size_y;
      split_axis(r.query_x, size_x, bx, wx[0], wx[1]);
      split_axis(r.query_y, size_y, by, wy[0], wy[1]);
      split_axis(r.query_z, size_z, bz, wz[0], wz[1]);
      for (int k = 0; k < 8; k++) begin
         dx = k & 1;
         dy = (k >> 1) & 1;
         dz = (k >> 2) & 1;
         w[k] = wx[dx] * wy[dy] * wz[dz];
         addr[k] = ((bz + dz) * syl + by + dy) * sxl + bx + dx;
      end
   endfunction

   // weighted mean of the observed in-range corners, rounded half up
   function automatic rsp_type sample_mean(input req_type r);
      longint w[8];
      int addr[8];
      longint total, hi_sum, lo_sum, v, vl, vh, q, rem, res;
      logic [16:0] cell_word;
      rsp_type s;
      total = 0;
      hi_sum = 0;
      lo_sum = 0;
      corner_weights(r, w, addr);
      for (int k = 0; k < 8; k++) begin
         if (w[k] > 0 && addr[k] >= 0 && addr[k] < STORE_DEPTH) begin
            cell_word = volume_copy.exists(addr[k]) ? volume_copy[addr[k]] : 17'd0;
            if (cell_word[16]) begin
               v = $signed(cell_word[15:0]);
               vl = v & 64'hffff;
               vh = (v - vl) / 65536;
               total += w[k];
               hi_sum += vh * w[k];
               lo_sum += vl * w[k];
            end
         end
      end
      s = '0;
      if (total != 0) begin
         q = hi_sum / total;
         rem = hi_sum - q * total;
         if (rem < 0) begin
            rem += total;
            q -= 1;
         end
         res = q * 65536 + (2 * (rem * 65536 + lo_sum) + total) / (2 * total);
         if (res > 32767) res = 32767;
         if (res < -32768) res = -32768;
         s.sample_value = res[15:0];
         s.sample_found = 1'b1;
      end
      return s;
   endfunction

   function automatic req_type random_cmd();
      req_type r;
      r.opcode = OPCODE_W'($urandom_range(1));
      r.voxel_address = ADDR_FIELD_W'($urandom_range(STORE_DEPTH - 1));
      r.voxel_value = DIST_W'($urandom);
      r.voxel_observed = ($urandom_range(99) < 75);
      r.query_x = COORD_W'($urandom);
      r.query_y = COORD_W'($urandom);
      r.query_z = COORD_W'($urandom);
      return r;
   endfunction

   task automatic push_voxel(input int a, input logic [15:0] val, input bit obs);
      req_type r;
      r = random_cmd();
      r.opcode = OP_WRITE;
      r.voxel_address = ADDR_FIELD_W'(a);
      r.voxel_value = val;
      r.voxel_observed = obs;
      planned_voxels[a] = 1;
      pending_cmds.push_back(r);
   endtask

   // queries first load any weighted corner that was never written
   task automatic push_query(input req_type r);
      longint w[8];
      int addr[8];
      r.opcode = OP_QUERY;
      corner_weights(r, w, addr);
      for (int k = 0; k < 8; k++)
         if (w[k] > 0 && !planned_voxels.exists(addr[k]))
            push_voxel(addr[k], 16'($urandom), $urandom_range(99) < 75);
      pending_cmds.push_back(r);
   endtask

   task automatic push_point(input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
      req_type r;
      r = random_cmd();
      r.query_x = x;
      r.query_y = y;
      r.query_z = z;
      push_query(r);
   endtask

   function automatic logic [15:0] random_coord(input int size);
      int lim;
      logic [15:0] c;
      lim = (size > 64) ? 64 : size;
      if ($urandom_range(99) < 10) return 16'($urandom);
      c[15:8] = 8'(int'($urandom_range(lim + 1)) - 1);
      c[7:0] = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom);
      return c;
   endfunction

   task automatic wait_drained();
      while (pending_cmds.size() != 0 || start || expected_samples.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_size(input logic [CSR_IDX_W-1:0] idx, input int val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= SIZE_W'(val);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_SIZE_X: size_x = val;
         CSR_SIZE_Y: size_y = val;
         default: size_z = val;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(input int n);
      int lx, ly, lz;
      lx = (size_x > 64) ? 64 : size_x;
      ly = (size_y > 64) ? 64 : size_y;
      lz = (size_z > 64) ? 64 : size_z;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 30) begin
            if (lx * ly * lz > 0 && $urandom_range(1))
               push_voxel((int'($urandom_range(lz - 1)) * ly + int'($urandom_range(ly - 1)))
                          * lx + int'($urandom_range(lx - 1)), 16'($urandom),
                          $urandom_range(99) < 75);
            else
               push_voxel(int'($urandom_range(STORE_DEPTH - 1)), 16'($urandom),
                          $urandom_range(99) < 75);
         end else begin
            push_point(random_coord(size_x), random_coord(size_y), random_coord(size_z));
         end
      end
      wait_drained();
   endtask

   task automatic set_sizes(input int x, input int y, input int z);
      write_size(CSR_SIZE_X, x);
      write_size(CSR_SIZE_Y, y);
      write_size(CSR_SIZE_Z, z);
   endtask

   // command driver: holds start until the beat is taken
   always @(negedge clock) begin
      if (!reset && (!start || beat_taken)) begin
         beat_taken = 0;
         if (pending_cmds.size() != 0 &&
             ((drive_count > 700 && drive_count < 1000) || $urandom_range(99) >= 37)) begin
            req_data <= pending_cmds.pop_front();
            start <= 1'b1;
            drive_count++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: predicts at each accepted beat, checks each response beat
   always @(posedge clock) begin
      rsp_type exp_s;
      if (!reset) begin
         if (start && !busy) begin
            beat_taken = 1;
            if (req_data.opcode == OP_WRITE) begin
               volume_copy[req_data.voxel_address] = {req_data.voxel_observed,
                                                      req_data.voxel_value};
               write_count++;
            end else begin
               exp_s = sample_mean(req_data);
               expected_samples.push_back(exp_s);
               query_count++;
               if (exp_s.sample_found) found_count++;
            end
         end
         if (rsp_valid) begin
            if (expected_samples.size() == 0) begin
               $display("%0t: unexpected response beat, actual value %0d found %0b",
                        $time, rsp_data.sample_value, rsp_data.sample_found);
               fail_count++;
            end else begin
               exp_s = expected_samples.pop_front();
               if (rsp_data.sample_value !== exp_s.sample_value) begin
                  $display("%0t: sample_value expected %0d actual %0d", $time,
                           exp_s.sample_value, rsp_data.sample_value);
                  fail_count++;
               end
               if (rsp_data.sample_found !== exp_s.sample_found) begin
                  $display("%0t: sample_found expected %0b actual %0b", $time,
                           exp_s.sample_found, rsp_data.sample_found);
                  fail_count++;
               end
            end
         end
      end
   end

   // main sequence
   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extreme values, ties, unobserved and out-of-range corners
      push_voxel(0, 16'h7fff, 1);
      push_voxel(1, 16'h8000, 1);
      push_voxel(64, 16'h0000, 0);
      push_voxel(4096, 16'd12345, 1);
      push_voxel(STORE_DEPTH - 1, 16'hffff, 1);
      push_point(16'h0000, 16'h0000, 16'h0000);
      push_point(16'h0080, 16'h0000, 16'h0000);
      push_point(16'h0000, 16'h0100, 16'h0000);
      push_point(16'hff00, 16'h0000, 16'h0000);
      push_point(16'hff80, 16'h0000, 16'h0000);
      push_point(16'h7fff, 16'h7fff, 16'h7fff);
      push_point(16'h8000, 16'h8000, 16'h8000);
      push_point(16'h00ff, 16'h00ff, 16'h00ff);
      push_point(16'h3f80, 16'h3f80, 16'h3f80);
      push_point(16'h3f00, 16'h3f00, 16'h3f00);
      push_point(16'h0000, 16'h0000, 16'h0100);
      push_voxel(0, 16'h8000, 1);
      push_point(16'h0080, 16'h0000, 16'h0000);
      push_voxel(1, 16'h1234, 0);
      push_point(16'h0080, 16'h0000, 16'h0000);
      wait_drained();

      // queries in large volumes also load their corners, so those phases are short
      random_phase(80);
      set_sizes(1, 1, 1);
      random_phase(100);
      set_sizes(5, 3, 7);
      random_phase(150);
      set_sizes(0, 4, 4);
      random_phase(80);
      set_sizes(127, 127, 127);
      random_phase(60);
      set_sizes(64, 1, 2);
      random_phase(120);
      set_sizes(2, 64, 2);
      random_phase(120);
      set_sizes(64, 64, 64);
      random_phase(50);

      $display("covered %0d voxel writes and %0d queries, %0d of them found",
               write_count, query_count, found_count);
      $display("sizes from zero and one voxel up to saturated registers");
      if (fail_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // run time limit
   initial begin
      #(20 * 2000000);
      $display("end of test: mismatches");
      $finish;
   end

endmodule
